FILE: rtl/gscs_pkg.sv
package gscs_pkg;

  // report id of the full input report
  localparam logic [7:0] ID_FULL = 8'h30;

  localparam int NUM_AXES = 4;
  localparam int AXIS_W = 12;
  localparam int BTN_IN_W = 24;
  localparam int BTN_OUT_W = 18;

  // change threshold on raw axes
  localparam logic [AXIS_W-1:0] DIFF_LIMIT = 12'd4;

  // single grip offset added or removed before scaling
  localparam logic [15:0] HALF_OFFSET = 16'd127;

  // pro scaling numerator |v - centre| * 127 stays below 2^PRO_NUM_W
  localparam int PRO_NUM_W = 20;
  localparam logic [7:0] PRO_MAX = 8'd127;

  // datapath widths of the reciprocal multiply
  localparam int NUM_W = 24;
  localparam int RECIP_W = 25;
  localparam int PROD_W = NUM_W + RECIP_W;
  localparam int Q_W = 20;

  // single grip divide by 4095, numerator below 2^24
  localparam int HALF_SPAN = 4095;
  localparam int HALF_SHIFT = 36;
  localparam logic [63:0] HALF_RECIP =
    ((64'd1 << HALF_SHIFT) + 64'(HALF_SPAN) - 64'd1) / 64'(HALF_SPAN);

  typedef struct packed {
    logic [7:0]  rpt_id;
    logic [23:0] lstick;
    logic [23:0] rstick;
    logic [23:0] button_bits;
  } in_item_t;

  typedef struct packed {
    logic [17:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
  } out_item_t;

  typedef enum logic [1:0] {
    AXIS_ZERO,
    AXIS_PRO,
    AXIS_HALF
  } axis_kind_t;

  typedef struct packed {
    axis_kind_t       kind;
    logic             inv;   // y axis, output is 255 - value
    logic             neg;   // pro: axis below centre
    logic             one;   // half: operand is zero, scale gives 1
    logic [NUM_W-1:0] num;   // dividend of the reciprocal multiply
  } axis_op_t;

  typedef struct packed {
    logic [BTN_OUT_W-1:0]             buttons;
    axis_op_t [NUM_AXES-1:0]          ops;
  } trk_t;

endpackage

FILE: rtl/gamepad_stick_calibrate_scale.sv
// throughput: one report per cycle; every stage moves when the stage after it has room
// stages: input register, tracking and operand register, reciprocal product register,
// result register; the product stage holds one 24x25 multiplier per axis
// reset: synchronous active low, clears pro_mode, centres, calibration count and history
module gamepad_stick_calibrate_scale #(
  parameter int CAL_REPORTS = 4,
  parameter int STICK_SPAN  = 1600
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gscs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gscs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic pro_mode_r;

  logic                     v1_r, v2, v3_r, v4_r;
  logic                     rdy1, rdy2, rdy3, rdy4;
  gscs_pkg::in_item_t       in1_r;
  gscs_pkg::trk_t           trk;
  logic [gscs_pkg::BTN_OUT_W-1:0]        btn3_r;
  logic [gscs_pkg::NUM_AXES-1:0][7:0]    axis_val;
  gscs_pkg::out_item_t      out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) pro_mode_r <= 1'b0;
    else if (cfg_valid && cfg_ready) pro_mode_r <= cfg_data;
  end

  // a stage takes a new item when it is empty or its item moves on
  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy3) v3_r <= v2;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) in1_r <= in_data;
    if (rdy3) btn3_r <= trk.buttons;
    if (rdy4) out_r <= {btn3_r, axis_val[0], axis_val[1], axis_val[2], axis_val[3]};
  end

  gscs_track #(
    .CAL_REPORTS (CAL_REPORTS)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .pro_mode (pro_mode_r),
    .in_vld   (v1_r),
    .item     (in1_r),
    .adv      (rdy2),
    .out_vld  (v2),
    .trk      (trk)
  );

  for (genvar i = 0; i < gscs_pkg::NUM_AXES; i++) begin : g_axis
    gscs_axis #(
      .STICK_SPAN (STICK_SPAN)
    ) u_axis (
      .clk (clk),
      .en  (rdy3),
      .op  (trk.ops[i]),
      .val (axis_val[i])
    );
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/gscs_track.sv
module gscs_track #(
  parameter int CAL_REPORTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pro_mode,
  input  logic               in_vld,
  input  gscs_pkg::in_item_t item,
  input  logic               adv,
  output logic               out_vld,
  output gscs_pkg::trk_t     trk
);

  localparam int CNT_W = $clog2(CAL_REPORTS + 1);
  localparam int AW = gscs_pkg::AXIS_W;

  logic [gscs_pkg::NUM_AXES-1:0][AW-1:0] ax;
  logic [gscs_pkg::NUM_AXES-1:0][AW-1:0] centre_r, centre_nxt;
  logic [gscs_pkg::NUM_AXES-1:0][AW-1:0] prev_r, prev_nxt;
  logic [gscs_pkg::BTN_IN_W-1:0]         prev_btn_r, prev_btn_nxt;
  logic [CNT_W-1:0]                      cnt_r, cnt_nxt;
  logic                                  vld_r;
  gscs_pkg::trk_t                        trk_r, trk_nxt;

  logic [gscs_pkg::BTN_IN_W-1:0] bb;
  logic                          id_ok, cal, changed, emit, consume;
  logic                          left_half, right_half;
  logic [gscs_pkg::NUM_AXES-1:0][15:0] hv;

  function automatic logic [AW-1:0] abs_diff(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] d;
    begin
      d = {1'b0, a} - {1'b0, b};
      abs_diff = d[AW] ? AW'(-d) : d[AW-1:0];
    end
  endfunction

  // (v - 1) * 255 for the single grip scaling
  function automatic logic [gscs_pkg::NUM_W-1:0] half_num(input logic [15:0] v);
    logic [15:0] vm;
    begin
      vm = v - 16'd1;
      half_num = {vm, 8'd0} - {8'd0, vm};
    end
  endfunction

  assign bb = item.button_bits;
  assign ax[0] = item.lstick[11:0];
  assign ax[1] = item.lstick[23:12];
  assign ax[2] = item.rstick[11:0];
  assign ax[3] = item.rstick[23:12];

  assign id_ok   = (item.rpt_id == gscs_pkg::ID_FULL);
  assign cal     = pro_mode && (cnt_r < CNT_W'(CAL_REPORTS));
  assign consume = in_vld && adv && id_ok;
  assign emit    = id_ok && !cal && changed;

  assign left_half  = (ax[2] == '0) && (ax[3] == '0);
  assign right_half = !left_half && (ax[0] == '0) && (ax[1] == '0);

  assign hv[0] = 16'(ax[0]) + gscs_pkg::HALF_OFFSET;
  assign hv[1] = 16'(ax[1]) - gscs_pkg::HALF_OFFSET;
  assign hv[2] = 16'(ax[2]);
  assign hv[3] = 16'(ax[3]) + gscs_pkg::HALF_OFFSET;

  always_comb begin
    changed = (bb != prev_btn_r);
    for (int i = 0; i < gscs_pkg::NUM_AXES; i++) begin
      if (abs_diff(ax[i], prev_r[i]) > gscs_pkg::DIFF_LIMIT) changed = 1'b1;
    end
  end

  // state update
  always_comb begin
    centre_nxt   = centre_r;
    prev_nxt     = prev_r;
    prev_btn_nxt = prev_btn_r;
    cnt_nxt      = cnt_r;
    if (consume && cal) begin
      for (int i = 0; i < gscs_pkg::NUM_AXES; i++) begin
        centre_nxt[i] = (cnt_r == '0) ? ax[i] :
                        AW'(({1'b0, centre_r[i]} + {1'b0, ax[i]}) >> 1);
      end
      prev_nxt     = ax;
      prev_btn_nxt = bb;
      cnt_nxt      = cnt_r + CNT_W'(1);
    end else if (consume && emit) begin
      prev_nxt     = ax;
      prev_btn_nxt = bb;
    end
  end

  // operands and button map
  always_comb begin
    logic [AW:0]   d;
    logic [AW-1:0] mag;
    logic          up, down, lft, rgt, home, start;
    trk_nxt = '0;
    for (int i = 0; i < gscs_pkg::NUM_AXES; i++) begin
      d   = {1'b0, ax[i]} - {1'b0, centre_r[i]};
      mag = d[AW] ? AW'(-d) : d[AW-1:0];
      trk_nxt.ops[i].inv = (i % 2) == 1;
      if (pro_mode) begin
        trk_nxt.ops[i].kind = gscs_pkg::AXIS_PRO;
        trk_nxt.ops[i].neg  = d[AW];
        trk_nxt.ops[i].num  = gscs_pkg::NUM_W'({mag, 7'd0} - {7'd0, mag});
      end else if ((left_half && i < 2) || (right_half && i >= 2)) begin
        trk_nxt.ops[i].kind = gscs_pkg::AXIS_HALF;
        trk_nxt.ops[i].one  = (hv[i] == '0);
        trk_nxt.ops[i].num  = half_num(hv[i]);
      end else begin
        trk_nxt.ops[i].kind = gscs_pkg::AXIS_ZERO;
      end
    end

    up    = bb[17];
    down  = bb[16];
    rgt   = bb[18];
    lft   = bb[19];
    home  = bb[12];
    start = bb[9];
    if (!pro_mode && left_half) begin
      start = 1'b0;
    end else if (!pro_mode && right_half) begin
      up   = 1'b0;
      down = 1'b0;
      lft  = 1'b0;
      rgt  = 1'b0;
      home = 1'b0;
    end
    trk_nxt.buttons = {bb[13], home, bb[10], bb[11], start, bb[8],
                       bb[4] | bb[7], bb[20] | bb[23], bb[6], bb[22],
                       bb[1], bb[0], bb[3], bb[2], rgt, lft, down, up};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r   <= '0;
      prev_r     <= '0;
      prev_btn_r <= '0;
      cnt_r      <= '0;
      vld_r      <= 1'b0;
    end else begin
      centre_r   <= centre_nxt;
      prev_r     <= prev_nxt;
      prev_btn_r <= prev_btn_nxt;
      cnt_r      <= cnt_nxt;
      if (adv) vld_r <= in_vld && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) trk_r <= trk_nxt;
  end

  assign out_vld = vld_r;
  assign trk     = trk_r;

endmodule

FILE: rtl/gscs_axis.sv
module gscs_axis #(
  parameter int STICK_SPAN = 1600
) (
  input  logic               clk,
  input  logic               en,
  input  gscs_pkg::axis_op_t op,
  output logic [7:0]         val
);

  // exact floor divide by STICK_SPAN for numerators below 2^PRO_NUM_W
  localparam int SPAN_SHIFT = gscs_pkg::PRO_NUM_W + $clog2(STICK_SPAN);
  localparam logic [63:0] SPAN_RECIP =
    ((64'd1 << SPAN_SHIFT) + 64'(STICK_SPAN) - 64'd1) / 64'(STICK_SPAN);

  logic [gscs_pkg::PROD_W-1:0]  prod_r;
  gscs_pkg::axis_kind_t         kind_r;
  logic                         inv_r, neg_r, one_r;
  logic [gscs_pkg::RECIP_W-1:0] recip;
  logic [gscs_pkg::Q_W-1:0]     q;
  logic [7:0]                   base;

  assign recip = (op.kind == gscs_pkg::AXIS_PRO) ? gscs_pkg::RECIP_W'(SPAN_RECIP) :
                                                   gscs_pkg::RECIP_W'(gscs_pkg::HALF_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= gscs_pkg::PROD_W'(op.num) * gscs_pkg::PROD_W'(recip);
      kind_r <= op.kind;
      inv_r  <= op.inv;
      neg_r  <= op.neg;
      one_r  <= op.one;
    end
  end

  always_comb begin
    q    = '0;
    base = '0;
    val  = '0;
    unique case (kind_r)
      gscs_pkg::AXIS_PRO: begin
        q = gscs_pkg::Q_W'(prod_r >> SPAN_SHIFT);
        // clamp to -128..127 and move to 0..255
        if (!neg_r) base = (q > gscs_pkg::Q_W'(gscs_pkg::PRO_MAX)) ? 8'd255 : {1'b1, q[6:0]};
        else        base = (q > gscs_pkg::Q_W'(gscs_pkg::PRO_MAX)) ? 8'd0 : 8'd128 - q[7:0];
        val = inv_r ? ~base : base;
      end
      gscs_pkg::AXIS_HALF: begin
        q    = gscs_pkg::Q_W'(prod_r >> gscs_pkg::HALF_SHIFT);
        base = one_r ? 8'd1 : q[7:0] + 8'd1;
        val  = inv_r ? ~base : base;
      end
      default: val = '0;
    endcase
  end

endmodule

FILE: bench/gamepad_stick_calibrate_scale_tb.sv
module gamepad_stick_calibrate_scale_tb;

  localparam int CAL_REPORTS = 4;
  localparam int STICK_SPAN = 1600;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES = 400000;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gscs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gscs_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  gamepad_stick_calibrate_scale #(
    .CAL_REPORTS(CAL_REPORTS),
    .STICK_SPAN(STICK_SPAN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic pro_sel = 1'b0;
  logic [2:0] cal_seen = '0;
  logic [11:0] axis_mid [4] = '{default: '0};
  logic [11:0] last_axes [4] = '{default: '0};
  logic [23:0] last_buttons = '0;
  gscs_pkg::out_item_t expected_results [$];

  // stimulus state
  gscs_pkg::in_item_t report_queue [$];
  logic [11:0] gen_ax [4] = '{default: 12'd2048};
  logic [23:0] gen_btn = '0;
  int items_queued = 0;
  int items_taken = 0;
  bit bursty = 1'b0;
  stall_style_t stall_style = STALL_NONE;
  int hold_asks = 0;

  // counters
  int errors = 0;
  int n_results = 0;
  int n_ignored = 0;
  int n_quiet = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] pro_scale(logic [11:0] v, logic [11:0] c);
    int d;
    int s;
    d = int'(v) - int'(c);
    s = (d * 127) / STICK_SPAN;
    if (s < -128) s = -128;
    if (s > 127) s = 127;
    return 8'(s + 128);
  endfunction

  function automatic logic [7:0] half_scale(int unsigned v);
    v = v & 32'hFFFF;
    if (v == 0) return 8'd1;
    return 8'(1 + ((v - 1) * 255) / 4095);
  endfunction

  function automatic void predict_report(gscs_pkg::in_item_t rpt);
    logic [11:0] ax [4];
    logic [7:0] res [4];
    logic [11:0] gap;
    logic [23:0] bb;
    logic up, down, left, right, home, start;
    bit moved;
    gscs_pkg::out_item_t want;
    if (rpt.rpt_id != gscs_pkg::ID_FULL) begin
      n_ignored++;
      return;
    end
    bb = rpt.button_bits;
    ax[0] = rpt.lstick[11:0];
    ax[1] = rpt.lstick[23:12];
    ax[2] = rpt.rstick[11:0];
    ax[3] = rpt.rstick[23:12];
    if (pro_sel && cal_seen < CAL_REPORTS) begin
      for (int i = 0; i < 4; i++) begin
        if (cal_seen == 0) axis_mid[i] = ax[i];
        else axis_mid[i] = 12'(({1'b0, axis_mid[i]} + {1'b0, ax[i]}) >> 1);
        last_axes[i] = ax[i];
      end
      cal_seen = cal_seen + 3'd1;
      last_buttons = bb;
      n_quiet++;
      return;
    end
    moved = (bb != last_buttons);
    for (int i = 0; i < 4; i++) begin
      gap = (ax[i] > last_axes[i]) ? ax[i] - last_axes[i] : last_axes[i] - ax[i];
      if (gap > gscs_pkg::DIFF_LIMIT) moved = 1'b1;
    end
    if (!moved) begin
      n_quiet++;
      return;
    end
    up = bb[17];
    down = bb[16];
    right = bb[18];
    left = bb[19];
    home = bb[12];
    start = bb[9];
    res = '{default: '0};
    if (pro_sel) begin
      res[0] = pro_scale(ax[0], axis_mid[0]);
      res[1] = 8'd255 - pro_scale(ax[1], axis_mid[1]);
      res[2] = pro_scale(ax[2], axis_mid[2]);
      res[3] = 8'd255 - pro_scale(ax[3], axis_mid[3]);
    end else if (ax[2] == 0 && ax[3] == 0) begin
      // left half only
      start = 1'b0;
      res[0] = half_scale({20'd0, ax[0]} + 32'(gscs_pkg::HALF_OFFSET));
      res[1] = 8'd255 - half_scale({20'd0, ax[1]} - 32'(gscs_pkg::HALF_OFFSET));
    end else if (ax[0] == 0 && ax[1] == 0) begin
      // right half only
      {up, down, left, right, home} = '0;
      res[2] = half_scale({20'd0, ax[2]});
      res[3] = 8'd255 - half_scale({20'd0, ax[3]} + 32'(gscs_pkg::HALF_OFFSET));
    end
    want.buttons = {bb[13], home, bb[10], bb[11], start, bb[8], bb[4] | bb[7],
                    bb[20] | bb[23], bb[6], bb[22], bb[1], bb[0], bb[3], bb[2],
                    right, left, down, up};
    want.left_x = res[0];
    want.left_y = res[1];
    want.right_x = res[2];
    want.right_y = res[3];
    expected_results.push_back(want);
    last_axes = ax;
    last_buttons = bb;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(gscs_pkg::out_item_t got);
    gscs_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: %h", got);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    check_field("buttons", want.buttons, got.buttons);
    check_field("left_x", want.left_x, got.left_x);
    check_field("left_y", want.left_y, got.left_y);
    check_field("right_x", want.right_x, got.right_x);
    check_field("right_y", want.right_y, got.right_y);
    n_results++;
  endtask

  // monitor: both transfers are taken at the rising edge
  logic in_fire = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) begin
        predict_report(in_data);
        items_taken++;
      end
      in_fire <= in_valid && !in_stall;
    end
  end

  // driver: bursts of reports, with random gaps when bursty is set
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (report_queue.size() > 0) begin
        in_data <= report_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= bursty ? $urandom_range(0, 6) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  int hold_left = 0;
  int hold_done = 0;
  int pat_cnt = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      out_stall <= 1'b1;
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      case (stall_style)
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        STALL_RUNS: begin
          out_stall <= (pat_cnt % 7) >= 4;
          pat_cnt <= pat_cnt + 1;
        end
        default: begin
          out_stall <= 1'b0;
        end
      endcase
    end
  end

  function automatic gscs_pkg::in_item_t make_report(logic [7:0] id, logic [11:0] lx,
                                                     logic [11:0] ly, logic [11:0] rx,
                                                     logic [11:0] ry, logic [23:0] btn);
    gscs_pkg::in_item_t r;
    r.rpt_id = id;
    r.lstick = {ly, lx};
    r.rstick = {ry, rx};
    r.button_bits = btn;
    return r;
  endfunction

  function automatic logic [11:0] pick_axis();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'hFFF;
      2, 3: return 12'($urandom_range(0, 200));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [11:0] nudge(logic [11:0] v);
    int t;
    t = int'(v) + $urandom_range(0, 12) - 6;
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return 12'(t);
  endfunction

  function automatic gscs_pkg::in_item_t random_report(bit pro);
    logic [7:0] id;
    int pick;
    int shape;
    id = gscs_pkg::ID_FULL;
    if ($urandom_range(0, 11) == 0) id = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 12) begin
      if (pick < 35) begin
        // small moves around the change threshold
        for (int i = 0; i < 4; i++) gen_ax[i] = nudge(gen_ax[i]);
      end else if (pro) begin
        for (int i = 0; i < 4; i++) begin
          shape = $urandom_range(0, 9);
          if (shape == 0) gen_ax[i] = 12'd0;
          else if (shape == 1) gen_ax[i] = 12'hFFF;
          else if (shape < 6) gen_ax[i] = 12'($urandom_range(1798, 2298));
          else gen_ax[i] = 12'($urandom_range(0, 4095));
        end
      end else begin
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++) gen_ax[i] = pick_axis();
        if (shape < 4) begin
          gen_ax[2] = 12'd0;
          gen_ax[3] = 12'd0;
        end else if (shape < 7) begin
          gen_ax[0] = 12'd0;
          gen_ax[1] = 12'd0;
        end else if (shape == 9) begin
          gen_ax = '{default: '0};
        end
      end
      case ($urandom_range(0, 3))
        2: gen_btn[$urandom_range(0, 23)] = ~gen_btn[$urandom_range(0, 23)];
        3: gen_btn = 24'($urandom);
        default: ;
      endcase
    end
    return make_report(id, gen_ax[0], gen_ax[1], gen_ax[2], gen_ax[3], gen_btn);
  endfunction

  task automatic push_report(gscs_pkg::in_item_t r);
    report_queue.push_back(r);
    items_queued++;
  endtask

  task automatic queue_random(bit pro, int count);
    gscs_pkg::in_item_t r;
    int counted;
    counted = 0;
    while (counted < count) begin
      r = random_report(pro);
      counted++;
      push_report(r);
    end
  endtask

  task automatic drain();
    while (items_taken != items_queued) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // reports without a result may still be in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = m;
    do @(posedge clk); while (!cfg_ready);
    pro_sel = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // single grip, directed
    write_mode(1'b0);
    push_report(make_report(gscs_pkg::ID_FULL, 12'd0, 12'd0, 12'd0, 12'd0, 24'hFFFFFF));
    push_report(make_report(gscs_pkg::ID_FULL, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 24'h000000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd100, 12'd127, 12'd0, 12'd0, 24'h000200));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 24'hFFFFFF));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd0, 12'd0, 12'd0, 12'd5, 24'h0F1000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd0, 12'd0, 12'd1, 12'd0, 24'h0F1000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2048, 12'd2048, 12'd2048, 12'd2048,
                            24'h00C000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2048, 12'd2048, 12'd2048, 12'd2048,
                            24'h00C000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2052, 12'd2044, 12'd2048, 12'd2048,
                            24'h00C000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2053, 12'd2044, 12'd2048, 12'd2048,
                            24'h00C000));
    push_report(make_report(8'h31, 12'd7, 12'd900, 12'd0, 12'd3000, 24'h123456));
    push_report(make_report(8'h00, 12'd0, 12'd0, 12'd0, 12'd0, 24'h000000));
    push_report(make_report(8'hFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2053, 12'd2044, 12'd2048, 12'd2048,
                            24'h000000));
    drain();

    // pro mode, calibration then directed scaling
    write_mode(1'b1);
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2048, 12'd2048, 12'd2048, 12'd2048,
                            24'h000001));
    push_report(make_report(8'h2F, 12'd0, 12'd0, 12'd0, 12'd0, 24'hFFFFFF));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2000, 12'd2100, 12'd1990, 12'd2110,
                            24'h000002));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2060, 12'd2040, 12'd2030, 12'd2070,
                            24'h800000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2052, 12'd2044, 12'd2050, 12'd2046,
                            24'h800000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2052, 12'd2044, 12'd2050, 12'd2046,
                            24'h800000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd0, 12'd0, 12'd0, 12'd0, 24'h800000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                            24'h800000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2046, 12'd2046, 12'd2046, 12'd2046,
                            24'h000000));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2046, 12'd2046, 12'd2046, 12'd2046,
                            24'h5A5A5A));
    push_report(make_report(gscs_pkg::ID_FULL, 12'd2049, 12'd2046, 12'd2046, 12'd2046,
                            24'h5A5A5A));
    drain();

    // pro random traffic with one long receiver hold-off
    stall_style = STALL_RANDOM;
    bursty = 1'b1;
    queue_random(1'b1, 450);
    hold_asks++;
    drain();

    // back to single grip; calibration is kept
    write_mode(1'b0);
    stall_style = STALL_RUNS;
    bursty = 1'b0;
    queue_random(1'b0, 550);
    drain();

    write_mode(1'b1);
    stall_style = STALL_NONE;
    bursty = 1'b0;
    queue_random(1'b1, 200);
    drain();

    stall_style = STALL_RANDOM;
    bursty = 1'b1;
    queue_random(1'b1, 200);
    drain();

    $display("covered single grip halves, pro calibration and clamped scaling, mode switches");
    $display("%0d reports accepted: %0d results checked, %0d ignored ids, %0d without result",
             items_taken, n_results, n_ignored, n_quiet);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: gamepad_stick_calibrate_scale.f
rtl/gscs_pkg.sv
rtl/gscs_track.sv
rtl/gscs_axis.sv
rtl/gamepad_stick_calibrate_scale.sv
bench/gamepad_stick_calibrate_scale_tb.sv
